// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define ASSERT_CLKD(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("encoder port check failed");

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("encoder reset check failed");

`endif

// File: rtl/ipfe_pkg.sv
// Package of the IR pulse frame encoder: types, constants and register codes.
`default_nettype none

package ipfe_pkg;

    localparam int MAX_FIELD_BITS = 8;
    localparam int DURATION_BITS  = 15;

    localparam int VALUE_W = 8;
    localparam int DUR_W   = 15;
    localparam int TIMING_W = 2 * DUR_W;
    localparam int SMALL_W = 4;
    localparam int CFG_IDX_W = 3;

    // Counter wide enough to hold the clamped field width itself.
    localparam int CNT_W  = $clog2(MAX_FIELD_BITS + 1);
    localparam int BIDX_W = $clog2(VALUE_W);

    localparam logic [DUR_W-1:0] DUR_MASK = DUR_W'((64'd1 << DURATION_BITS) - 64'd1);

    localparam logic [TIMING_W-1:0] HEADER_TIMING_RST = TIMING_W'(294916500);
    localparam logic [TIMING_W-1:0] ONE_TIMING_RST    = TIMING_W'(18351770);
    localparam logic [TIMING_W-1:0] ZERO_TIMING_RST   = TIMING_W'(18350640);
    localparam logic [TIMING_W-1:0] STOP_TIMING_RST   = TIMING_W'(18350080);
    localparam logic [SMALL_W-1:0]  ADDR_WIDTH_RST    = SMALL_W'(8);
    localparam logic [SMALL_W-1:0]  CMD_WIDTH_RST     = SMALL_W'(8);
    localparam logic [SMALL_W-1:0]  FRAME_FLAGS_RST   = SMALL_W'(15);

    // Bit positions inside frame_flags.
    localparam int FLAG_LSB_FIRST = 0;
    localparam int FLAG_ADDR_INV  = 1;
    localparam int FLAG_CMD_INV   = 2;
    localparam int FLAG_STOP      = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_TIMING = 3'd0,
        REG_ONE_TIMING    = 3'd1,
        REG_ZERO_TIMING   = 3'd2,
        REG_STOP_TIMING   = 3'd3,
        REG_ADDR_WIDTH    = 3'd4,
        REG_CMD_WIDTH     = 3'd5,
        REG_FRAME_FLAGS   = 3'd6
    } reg_idx_t;

    // Frame sections in transmit order; DONE marks that nothing follows.
    typedef enum logic [2:0] {
        PH_HDR      = 3'd0,
        PH_ADDR     = 3'd1,
        PH_ADDR_INV = 3'd2,
        PH_CMD      = 3'd3,
        PH_CMD_INV  = 3'd4,
        PH_STOP     = 3'd5,
        PH_ERR      = 3'd6,
        PH_DONE     = 3'd7
    } phase_t;

    typedef struct packed {
        logic [VALUE_W-1:0] address;
        logic [VALUE_W-1:0] command;
    } in_t;

    typedef struct packed {
        logic [DUR_W-1:0] high_duration;
        logic [DUR_W-1:0] low_duration;
        logic             last;
        logic             status;
    } out_t;

    typedef struct packed {
        logic   load_in;
        logic   emit;
        phase_t phase;
        logic   last;
    } ctl_cmd_t;

    typedef struct packed {
        logic               fits;
        logic               out_free;
        logic               cnt_end;
        logic               addr_nz;
        logic               cmd_nz;
        logic [SMALL_W-1:0] flags;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/ipfe_dp.sv
// Datapath of the encoder: configuration registers, captured values, bit counter, output register.
`default_nettype none

module ipfe_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ipfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipfe_pkg::TIMING_W-1:0]  cfg_data,
    input  wire ipfe_pkg::in_t                 s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ipfe_pkg::out_t                     m_data,
    input  wire ipfe_pkg::ctl_cmd_t            cmd,
    output ipfe_pkg::dp_stat_t                 stat
);

    logic [ipfe_pkg::TIMING_W-1:0] header_timing_reg;
    logic [ipfe_pkg::TIMING_W-1:0] one_timing_reg;
    logic [ipfe_pkg::TIMING_W-1:0] zero_timing_reg;
    logic [ipfe_pkg::TIMING_W-1:0] stop_timing_reg;
    logic [ipfe_pkg::SMALL_W-1:0]  addr_width_reg;
    logic [ipfe_pkg::SMALL_W-1:0]  cmd_width_reg;
    logic [ipfe_pkg::SMALL_W-1:0]  frame_flags_reg;

    logic [ipfe_pkg::VALUE_W-1:0] addr_reg;
    logic [ipfe_pkg::VALUE_W-1:0] cmd_reg;
    logic [ipfe_pkg::CNT_W-1:0]   cnt_reg;
    logic [ipfe_pkg::CNT_W-1:0]   cnt_next;
    logic                         out_valid_reg;
    ipfe_pkg::out_t               out_data_reg;
    ipfe_pkg::out_t               out_data_next;

    logic [ipfe_pkg::CNT_W-1:0]  aw;
    logic [ipfe_pkg::CNT_W-1:0]  cw;
    logic [ipfe_pkg::CNT_W-1:0]  cur_w;
    logic [ipfe_pkg::CNT_W-1:0]  pos;
    logic [ipfe_pkg::VALUE_W-1:0] field_val;
    logic                        data_bit;
    logic                        is_data;
    logic [ipfe_pkg::TIMING_W-1:0] timing;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_timing_reg <= ipfe_pkg::HEADER_TIMING_RST;
            one_timing_reg    <= ipfe_pkg::ONE_TIMING_RST;
            zero_timing_reg   <= ipfe_pkg::ZERO_TIMING_RST;
            stop_timing_reg   <= ipfe_pkg::STOP_TIMING_RST;
            addr_width_reg    <= ipfe_pkg::ADDR_WIDTH_RST;
            cmd_width_reg     <= ipfe_pkg::CMD_WIDTH_RST;
            frame_flags_reg   <= ipfe_pkg::FRAME_FLAGS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ipfe_pkg::REG_HEADER_TIMING: header_timing_reg <= cfg_data;
                ipfe_pkg::REG_ONE_TIMING:    one_timing_reg    <= cfg_data;
                ipfe_pkg::REG_ZERO_TIMING:   zero_timing_reg   <= cfg_data;
                ipfe_pkg::REG_STOP_TIMING:   stop_timing_reg   <= cfg_data;
                ipfe_pkg::REG_ADDR_WIDTH:
                    addr_width_reg <= cfg_data[ipfe_pkg::SMALL_W-1:0];
                ipfe_pkg::REG_CMD_WIDTH:
                    cmd_width_reg <= cfg_data[ipfe_pkg::SMALL_W-1:0];
                ipfe_pkg::REG_FRAME_FLAGS:
                    frame_flags_reg <= cfg_data[ipfe_pkg::SMALL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Widths above the limit count as the limit, for checking and for sending.
    always_comb begin
        aw = (addr_width_reg > ipfe_pkg::SMALL_W'(ipfe_pkg::MAX_FIELD_BITS))
           ? ipfe_pkg::CNT_W'(ipfe_pkg::MAX_FIELD_BITS) : ipfe_pkg::CNT_W'(addr_width_reg);
        cw = (cmd_width_reg > ipfe_pkg::SMALL_W'(ipfe_pkg::MAX_FIELD_BITS))
           ? ipfe_pkg::CNT_W'(ipfe_pkg::MAX_FIELD_BITS) : ipfe_pkg::CNT_W'(cmd_width_reg);
    end

    always_comb begin
        is_data = (cmd.phase == ipfe_pkg::PH_ADDR) || (cmd.phase == ipfe_pkg::PH_ADDR_INV)
               || (cmd.phase == ipfe_pkg::PH_CMD) || (cmd.phase == ipfe_pkg::PH_CMD_INV);
        cur_w = ((cmd.phase == ipfe_pkg::PH_ADDR) || (cmd.phase == ipfe_pkg::PH_ADDR_INV))
              ? aw : cw;
        pos = frame_flags_reg[ipfe_pkg::FLAG_LSB_FIRST] ? cnt_reg
                                                        : cur_w - cnt_reg - 1'b1;
        unique case (cmd.phase)
            ipfe_pkg::PH_ADDR:     field_val = addr_reg;
            ipfe_pkg::PH_ADDR_INV: field_val = ~addr_reg;
            ipfe_pkg::PH_CMD:      field_val = cmd_reg;
            ipfe_pkg::PH_CMD_INV:  field_val = ~cmd_reg;
            default:               field_val = '0;
        endcase
        // Inverted fields only send bits below their width, so plain inversion suffices.
        data_bit = field_val[pos[ipfe_pkg::BIDX_W-1:0]];
    end

    always_comb begin
        unique case (cmd.phase)
            ipfe_pkg::PH_HDR:  timing = header_timing_reg;
            ipfe_pkg::PH_STOP: timing = stop_timing_reg;
            ipfe_pkg::PH_ADDR, ipfe_pkg::PH_ADDR_INV, ipfe_pkg::PH_CMD, ipfe_pkg::PH_CMD_INV:
                timing = data_bit ? one_timing_reg : zero_timing_reg;
            default: timing = '0;
        endcase
        out_data_next.high_duration =
            timing[ipfe_pkg::TIMING_W-1:ipfe_pkg::DUR_W] & ipfe_pkg::DUR_MASK;
        out_data_next.low_duration  = timing[ipfe_pkg::DUR_W-1:0] & ipfe_pkg::DUR_MASK;
        out_data_next.last          = cmd.last;
        out_data_next.status        = (cmd.phase == ipfe_pkg::PH_ERR);
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.load_in) begin
            cnt_next = '0;
        end else if (cmd.emit && is_data) begin
            cnt_next = stat.cnt_end ? '0 : cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            addr_reg <= s_data.address;
            cmd_reg  <= s_data.command;
        end
        if (cmd.emit) begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb begin
        stat.fits     = ((s_data.address >> aw) == '0) && ((s_data.command >> cw) == '0);
        stat.out_free = !out_valid_reg || m_ready;
        stat.cnt_end  = (cnt_reg == cur_w - 1'b1);
        stat.addr_nz  = (aw != '0);
        stat.cmd_nz   = (cw != '0);
        stat.flags    = frame_flags_reg;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/ipfe_ctrl.sv
// Controller of the encoder: steps through the sections of one frame.
`default_nettype none

module ipfe_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ipfe_pkg::dp_stat_t stat,
    output ipfe_pkg::ctl_cmd_t      cmd
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t           state_reg;
    ipfe_pkg::phase_t phase_reg;
    ipfe_pkg::phase_t phase_after;
    logic             has_a;
    logic             has_ai;
    logic             has_c;
    logic             has_ci;
    logic             has_s;
    logic             is_data;
    logic             more_bits;
    logic             last;

    // First enabled, non-empty section after the current one.
    always_comb begin
        has_a  = stat.addr_nz;
        has_ai = stat.addr_nz && stat.flags[ipfe_pkg::FLAG_ADDR_INV];
        has_c  = stat.cmd_nz;
        has_ci = stat.cmd_nz && stat.flags[ipfe_pkg::FLAG_CMD_INV];
        has_s  = stat.flags[ipfe_pkg::FLAG_STOP];
        priority if (phase_reg < ipfe_pkg::PH_ADDR && has_a) begin
            phase_after = ipfe_pkg::PH_ADDR;
        end else if (phase_reg < ipfe_pkg::PH_ADDR_INV && has_ai) begin
            phase_after = ipfe_pkg::PH_ADDR_INV;
        end else if (phase_reg < ipfe_pkg::PH_CMD && has_c) begin
            phase_after = ipfe_pkg::PH_CMD;
        end else if (phase_reg < ipfe_pkg::PH_CMD_INV && has_ci) begin
            phase_after = ipfe_pkg::PH_CMD_INV;
        end else if (phase_reg < ipfe_pkg::PH_STOP && has_s) begin
            phase_after = ipfe_pkg::PH_STOP;
        end else begin
            phase_after = ipfe_pkg::PH_DONE;
        end
    end

    always_comb begin
        is_data = (phase_reg == ipfe_pkg::PH_ADDR) || (phase_reg == ipfe_pkg::PH_ADDR_INV)
               || (phase_reg == ipfe_pkg::PH_CMD) || (phase_reg == ipfe_pkg::PH_CMD_INV);
        more_bits = is_data && !stat.cnt_end;
        last = (phase_reg == ipfe_pkg::PH_ERR)
            || (!more_bits && (phase_after == ipfe_pkg::PH_DONE));
        s_ready      = (state_reg == S_IDLE);
        cmd.load_in  = (state_reg == S_IDLE) && s_valid;
        cmd.emit     = (state_reg == S_RUN) && stat.out_free;
        cmd.phase    = phase_reg;
        cmd.last     = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= ipfe_pkg::PH_HDR;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        state_reg <= S_RUN;
                        phase_reg <= stat.fits ? ipfe_pkg::PH_HDR : ipfe_pkg::PH_ERR;
                    end
                end
                S_RUN: begin
                    if (stat.out_free) begin
                        if (last) begin
                            state_reg <= S_IDLE;
                        end else if (!more_bits) begin
                            phase_reg <= phase_after;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/ir_pulse_frame_encoder.sv
// Top level of the IR pulse frame encoder: controller and datapath.
//
// Use: write timing, width and flag registers over the cfg channel (index,
// data; always ready) while the block is idle. Each beat on the s_ channel
// carries one address and one command; the block answers with a run of pulse
// beats on the m_ channel: header, address bits, inverted address bits,
// command bits, inverted command bits and stop pulse as configured, the final
// beat flagged by last. A value wider than its configured width yields one
// beat with status set, zero durations and last set.
// First pulse: an accepted input beat moves the controller into its run state,
// from which the first pulse beat is registered into the output register.
// Throughput: one pulse beat per cycle while m_ready is high. The
// controller handles one frame at a time and takes the next input beat once
// the last pulse sits in the output register.
// Stall: a low m_ready holds the output register, and the frame waits.
// Reset: synchronous, active low; registers return to their defaults, the
// output register empties and the block is ready for a new beat.
`default_nettype none

module ir_pulse_frame_encoder (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ipfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ipfe_pkg::TIMING_W-1:0]  cfg_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ipfe_pkg::in_t                  s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ipfe_pkg::out_t                      m_data
);

    ipfe_pkg::ctl_cmd_t cmd;
    ipfe_pkg::dp_stat_t stat;

    ipfe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ipfe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: rtl/ipfe_checker.sv
// Port-level checker of the encoder and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module ipfe_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire ipfe_pkg::out_t m_data
);

    // A stalled result beat keeps its payload.
    `ASSERT_CLKD(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // One frame at a time: the input closes right after a beat is taken.
    `ASSERT_CLKD(a_one_frame, s_valid && s_ready |=> !s_ready)

    // While a non-final pulse is shown, the rest of the frame is still pending.
    `ASSERT_CLKD(a_busy_mid_frame, m_valid && !m_data.last |-> !s_ready)

    // An error beat stands alone and carries no durations.
    `ASSERT_CLKD(a_err_beat, m_valid && m_data.status |-> m_data.last
        && m_data.high_duration == '0 && m_data.low_duration == '0)

    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid)

endmodule

bind ir_pulse_frame_encoder ipfe_checker u_ipfe_checker (.*);

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the IR pulse frame encoder: predicted pulse frames against the m_ channel.
module tb_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD_AT = 1500;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_FRAMES = 38;
    localparam logic [ipfe_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic aclk;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ipfe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ipfe_pkg::TIMING_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    ipfe_pkg::in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ipfe_pkg::out_t m_data;

    ir_pulse_frame_encoder dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    // Shadow copy of the register file, updated on each accepted write beat.
    logic [ipfe_pkg::TIMING_W-1:0] hdr_timing = ipfe_pkg::HEADER_TIMING_RST;
    logic [ipfe_pkg::TIMING_W-1:0] one_timing = ipfe_pkg::ONE_TIMING_RST;
    logic [ipfe_pkg::TIMING_W-1:0] zero_timing = ipfe_pkg::ZERO_TIMING_RST;
    logic [ipfe_pkg::TIMING_W-1:0] stop_timing = ipfe_pkg::STOP_TIMING_RST;
    logic [ipfe_pkg::SMALL_W-1:0] addr_width = ipfe_pkg::ADDR_WIDTH_RST;
    logic [ipfe_pkg::SMALL_W-1:0] cmd_width = ipfe_pkg::CMD_WIDTH_RST;
    logic [ipfe_pkg::SMALL_W-1:0] frame_flags = ipfe_pkg::FRAME_FLAGS_RST;

    ipfe_pkg::in_t frame_req_q[$];
    ipfe_pkg::out_t want_pulses[$];

    logic s_fire = 1'b0;
    int gap_left = 0;
    int burst_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    int cycle_cnt = 0;
    int pulse_cnt = 0;
    int frames_in = 0;
    int rejected_frames = 0;
    int cfg_writes = 0;
    int err_cnt = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int sent_bits(input logic [ipfe_pkg::SMALL_W-1:0] w);
        return (w > ipfe_pkg::MAX_FIELD_BITS) ? ipfe_pkg::MAX_FIELD_BITS : int'(w);
    endfunction

    function automatic int field_mask(input logic [ipfe_pkg::SMALL_W-1:0] w);
        return (1 << sent_bits(w)) - 1;
    endfunction

    function automatic void append_want(input ipfe_pkg::out_t p);
        want_pulses.insert(want_pulses.size(), p);
    endfunction

    function automatic void push_pulse(input logic [ipfe_pkg::TIMING_W-1:0] t);
        ipfe_pkg::out_t p;
        p.high_duration = t[ipfe_pkg::TIMING_W-1:ipfe_pkg::DUR_W] & ipfe_pkg::DUR_MASK;
        p.low_duration = t[ipfe_pkg::DUR_W-1:0] & ipfe_pkg::DUR_MASK;
        p.last = 1'b0;
        p.status = 1'b0;
        append_want(p);
    endfunction

    function automatic void push_bits(input logic [ipfe_pkg::VALUE_W-1:0] v, input int n);
        int pos;
        for (int i = 0; i < n; i++) begin
            pos = frame_flags[ipfe_pkg::FLAG_LSB_FIRST] ? i : n - 1 - i;
            push_pulse(v[pos] ? one_timing : zero_timing);
        end
    endfunction

    // Expands one address/command beat into the pulse beats it must produce.
    function automatic void encode_frame(input ipfe_pkg::in_t req);
        int am;
        int cm;
        ipfe_pkg::out_t p;
        am = field_mask(addr_width);
        cm = field_mask(cmd_width);
        if (int'(req.address) > am || int'(req.command) > cm) begin
            p = '0;
            p.last = 1'b1;
            p.status = 1'b1;
            append_want(p);
            rejected_frames++;
            return;
        end
        push_pulse(hdr_timing);
        push_bits(req.address, sent_bits(addr_width));
        if (frame_flags[ipfe_pkg::FLAG_ADDR_INV])
            push_bits(~req.address & ipfe_pkg::VALUE_W'(am), sent_bits(addr_width));
        push_bits(req.command, sent_bits(cmd_width));
        if (frame_flags[ipfe_pkg::FLAG_CMD_INV])
            push_bits(~req.command & ipfe_pkg::VALUE_W'(cm), sent_bits(cmd_width));
        if (frame_flags[ipfe_pkg::FLAG_STOP])
            push_pulse(stop_timing);
        p = want_pulses.pop_back();
        p.last = 1'b1;
        append_want(p);
    endfunction

    task automatic flag_pulse(input string why, input ipfe_pkg::out_t want,
                              input ipfe_pkg::out_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t %s: want hi=%0d lo=%0d last=%0b st=%0b, got hi=%0d lo=%0d last=%0b st=%0b",
                     $realtime, why, want.high_duration, want.low_duration, want.last,
                     want.status, got.high_duration, got.low_duration, got.last, got.status);
    endtask

    // Sender: bursts of beats with random gaps; valid holds until the beat is taken.
    always @(negedge aclk) begin : sender
        logic nv;
        ipfe_pkg::in_t nd;
        nv = s_valid;
        nd = s_data;
        if (!s_valid || s_fire) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (frame_req_q.size() > 0) begin
                nd = frame_req_q.pop_front();
                nv = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
                end
            end
        end
        s_valid <= nv;
        s_data <= nd;
    end

    // Receiver: switches between stall patterns, plus one long hold-off mid-run.
    always @(negedge aclk) begin : receiver
        logic r;
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 200);
        end else begin
            rx_mode_left--;
        end
        if (!hold_done && pulse_cnt >= LONG_HOLD_AT) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
        end
        case (rx_mode)
            0: r = 1'b1;
            1: r = 1'($urandom_range(0, 1));
            2: r = ($urandom_range(0, 7) != 0);
            default: r = ($urandom_range(0, 7) == 0);
        endcase
        if (hold_left > 0) begin
            r = 1'b0;
            hold_left--;
        end
        m_ready <= r;
    end

    always @(posedge aclk) begin : scoreboard
        ipfe_pkg::out_t want;
        s_fire <= s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                pulse_cnt++;
                if (want_pulses.size() == 0) begin
                    flag_pulse("unexpected pulse", '0, m_data);
                end else begin
                    want = want_pulses.pop_front();
                    if (m_data.high_duration !== want.high_duration ||
                        m_data.low_duration !== want.low_duration ||
                        m_data.last !== want.last || m_data.status !== want.status)
                        flag_pulse("pulse mismatch", want, m_data);
                end
            end
            if (cfg_valid && cfg_ready) begin
                cfg_writes++;
                case (cfg_index)
                    ipfe_pkg::REG_HEADER_TIMING: hdr_timing = cfg_data;
                    ipfe_pkg::REG_ONE_TIMING: one_timing = cfg_data;
                    ipfe_pkg::REG_ZERO_TIMING: zero_timing = cfg_data;
                    ipfe_pkg::REG_STOP_TIMING: stop_timing = cfg_data;
                    ipfe_pkg::REG_ADDR_WIDTH: addr_width = cfg_data[ipfe_pkg::SMALL_W-1:0];
                    ipfe_pkg::REG_CMD_WIDTH: cmd_width = cfg_data[ipfe_pkg::SMALL_W-1:0];
                    ipfe_pkg::REG_FRAME_FLAGS: frame_flags = cfg_data[ipfe_pkg::SMALL_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                frames_in++;
                encode_frame(s_data);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout: %0d pulse beats still expected", want_pulses.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [ipfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipfe_pkg::TIMING_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send(input logic [ipfe_pkg::VALUE_W-1:0] a,
                        input logic [ipfe_pkg::VALUE_W-1:0] c);
        ipfe_pkg::in_t it;
        it.address = a;
        it.command = c;
        frame_req_q.insert(frame_req_q.size(), it);
    endtask

    task automatic wait_idle();
        while (frame_req_q.size() != 0 || s_valid || want_pulses.size() != 0)
            @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [ipfe_pkg::SMALL_W-1:0] aw;
        logic [ipfe_pkg::SMALL_W-1:0] cw;
        int am;
        int cm;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: full frames, then a write to an unmapped index.
        send(8'h00, 8'h00);
        send(8'hFF, 8'hFF);
        send(8'hA5, 8'h3C);
        wait_idle();
        write_reg(REG_UNMAPPED, '1);
        send(8'h01, 8'h80);

        // Zero widths, no options: header alone carries last; nonzero values are rejected.
        wait_idle();
        write_reg(ipfe_pkg::REG_ADDR_WIDTH, 30'd0);
        write_reg(ipfe_pkg::REG_CMD_WIDTH, 30'd0);
        write_reg(ipfe_pkg::REG_FRAME_FLAGS, 30'd0);
        send(8'h00, 8'h00);
        send(8'h01, 8'h00);
        send(8'h00, 8'hFF);

        // Widths above the limit clamp to eight; only the low nibble counts.
        wait_idle();
        write_reg(ipfe_pkg::REG_HEADER_TIMING, '1);
        write_reg(ipfe_pkg::REG_ONE_TIMING, '0);
        write_reg(ipfe_pkg::REG_ZERO_TIMING, 30'h2AAAAAAA);
        write_reg(ipfe_pkg::REG_STOP_TIMING, 30'h15555555);
        write_reg(ipfe_pkg::REG_ADDR_WIDTH, '1);
        write_reg(ipfe_pkg::REG_CMD_WIDTH, 30'h3FFFFFF9);
        write_reg(ipfe_pkg::REG_FRAME_FLAGS, 30'd14);
        send(8'hFF, 8'h00);
        send(8'h00, 8'hFF);
        send(8'h80, 8'h01);

        // Narrow fields: values one past the mask are rejected.
        wait_idle();
        write_reg(ipfe_pkg::REG_ADDR_WIDTH, 30'd3);
        write_reg(ipfe_pkg::REG_CMD_WIDTH, 30'd5);
        write_reg(ipfe_pkg::REG_FRAME_FLAGS, 30'd5);
        send(8'h08, 8'h00);
        send(8'h07, 8'h1F);
        send(8'h07, 8'h20);
        send(8'h00, 8'h1F);

        wait_idle();
        write_reg(ipfe_pkg::REG_ADDR_WIDTH, 30'd1);
        write_reg(ipfe_pkg::REG_CMD_WIDTH, 30'd0);
        write_reg(ipfe_pkg::REG_FRAME_FLAGS, 30'd2);
        send(8'h01, 8'h00);
        send(8'h00, 8'h00);
        send(8'h02, 8'h00);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            if (ph == 0) begin
                write_reg(ipfe_pkg::REG_HEADER_TIMING, '1);
                write_reg(ipfe_pkg::REG_ONE_TIMING, '1);
                write_reg(ipfe_pkg::REG_ZERO_TIMING, '1);
                write_reg(ipfe_pkg::REG_STOP_TIMING, '1);
            end else if (ph == 1) begin
                write_reg(ipfe_pkg::REG_HEADER_TIMING, '0);
                write_reg(ipfe_pkg::REG_ONE_TIMING, '0);
                write_reg(ipfe_pkg::REG_ZERO_TIMING, '0);
                write_reg(ipfe_pkg::REG_STOP_TIMING, '0);
            end else begin
                write_reg(ipfe_pkg::REG_HEADER_TIMING, ipfe_pkg::TIMING_W'($urandom));
                write_reg(ipfe_pkg::REG_ONE_TIMING, ipfe_pkg::TIMING_W'($urandom));
                write_reg(ipfe_pkg::REG_ZERO_TIMING, ipfe_pkg::TIMING_W'($urandom));
                write_reg(ipfe_pkg::REG_STOP_TIMING, ipfe_pkg::TIMING_W'($urandom));
            end
            if (ph == 2) begin
                aw = 4'd8;
                cw = 4'd8;
            end else if (ph == 3) begin
                aw = 4'd0;
                cw = 4'd0;
            end else begin
                aw = ipfe_pkg::SMALL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                    : $urandom_range(1, 8));
                cw = ipfe_pkg::SMALL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                                    : $urandom_range(1, 8));
            end
            write_reg(ipfe_pkg::REG_ADDR_WIDTH, ipfe_pkg::TIMING_W'(aw));
            write_reg(ipfe_pkg::REG_CMD_WIDTH, ipfe_pkg::TIMING_W'(cw));
            write_reg(ipfe_pkg::REG_FRAME_FLAGS,
                      (ph == 2) ? 30'd15 : ipfe_pkg::TIMING_W'($urandom_range(0, 15)));
            am = field_mask(aw);
            cm = field_mask(cw);
            // Mostly values that fit, so most beats produce full frames.
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                if ($urandom_range(0, 99) < 85)
                    send(ipfe_pkg::VALUE_W'($urandom & am), ipfe_pkg::VALUE_W'($urandom & cm));
                else
                    send(ipfe_pkg::VALUE_W'($urandom_range(0, 255)),
                         ipfe_pkg::VALUE_W'($urandom_range(0, 255)));
            end
        end

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("Run covered %0d frame requests (%0d rejected as too wide) and %0d pulse beats,",
                 frames_in, rejected_frames, pulse_cnt);
        $display("over %0d register writes; %0d pulse beats were wrong or unexpected.",
                 cfg_writes, err_cnt);
        if (err_cnt == 0 && want_pulses.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
